### rtl/pim_mem_mode_switch_policy_assert.svh
// Assertion macros for the mode switch policy block.
// PMSP_ASSERT_IMP checks cons in the same cycle as ante.
// PMSP_ASSERT_NXT checks cons in the cycle after ante.
`ifndef PIM_MEM_MODE_SWITCH_POLICY_ASSERT_SVH
`define PIM_MEM_MODE_SWITCH_POLICY_ASSERT_SVH

`ifndef SYNTHESIS

`define PMSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define PMSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define PMSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define PMSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/pmsp_pkg.sv
`timescale 1ns / 1ps

package pmsp_pkg;

	localparam int CYCLE_W   = 48;
	localparam int ROW_W     = 16;
	localparam int COUNT_W   = 32;
	localparam int CAP_W     = 16;
	localparam int SLOW_W    = 8;
	// switch-back cycle: now + slowdown * base, never above 2^56
	localparam int SBC_W     = CYCLE_W + SLOW_W;
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 104;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_PIM_CAP  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOWDOWN = 1'd1;

	localparam logic [CAP_W-1:0]  PIM_CAP_RST  = 16'd128;
	localparam logic [SLOW_W-1:0] SLOWDOWN_RST = 8'd2;

	typedef struct packed {
		logic [ROW_W-1:0]   issued_pim_row;
		logic               pim_issued;
		logic               mem_issued;
		logic [ROW_W-1:0]   next_pim_row;
		logic               pim_pending;
		logic               mem_pending;
		logic [CYCLE_W-1:0] cycle_now;
	} item_t;

	typedef struct packed {
		logic [CYCLE_W-1:0] wasted_cycles;
		logic [CYCLE_W-1:0] phase_time;
		logic               switched_to_pim;
		logic               switched_to_mem;
		logic               in_pim_mode;
	} result_t;

	typedef struct packed {
		logic [CAP_W-1:0]  pim_cap;
		logic [SLOW_W-1:0] slowdown_factor;
	} cfg_t;

endpackage

### rtl/pim_mem_mode_switch_policy.sv
`timescale 1ns / 1ps
// Channel  | Dir | Handshake          | Payload
// s_*      | in  | s_tvalid/s_tready  | s_tdata: one controller cycle item
// m_*      | out | m_tvalid/m_tready  | m_tdata: mode and switch result
// cfg_*    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per clock sustained while m_tready is high; an item passes the input register, then the result register.
// The policy state updates as an item moves into the result register.
// Reset clears the policy state and loads pim_cap = 128, slowdown_factor = 2.
// A stalled m_tready holds the result; one more item waits in the input register.
// cfg_ready is always high; writes to an unknown index are dropped.

`include "pim_mem_mode_switch_policy_assert.svh"

module pim_mem_mode_switch_policy import pmsp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// cycle_now[47:0], mem_pending[48], pim_pending[49], next_pim_row[65:50],
	// mem_issued[66], pim_issued[67], issued_pim_row[83:68], zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// in_pim_mode[0], switched_to_mem[1], switched_to_pim[2],
	// phase_time[50:3], wasted_cycles[98:51], zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int RES_W = $bits(result_t);
	localparam int ITEM_W = $bits(item_t);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    load;
	result_t res;
	result_t res_s2;

	// config registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pim_cap         <= PIM_CAP_RST;
			cfg_q.slowdown_factor <= SLOWDOWN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PIM_CAP:  cfg_q.pim_cap <= cfg_data;
				REG_SLOWDOWN: cfg_q.slowdown_factor <= cfg_data[SLOW_W-1:0];
				default: ;
			endcase
		end
	end

	// flow control
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign load     = s_tvalid && s_tready;

	pmsp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.advance  (advance),
		.item_in  (item_t'(s_tdata[ITEM_W-1:0])),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1)
	);

	pmsp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tdata = {{(OUT_DATA_W-RES_W){1'b0}}, res_s2};

	`PMSP_ASSERT_IMP(a_to_mem_mode, clk, arst_n, m_tvalid && res_s2.switched_to_mem, !res_s2.in_pim_mode, "switch to memory left PIM mode set")
	`PMSP_ASSERT_IMP(a_to_pim_mode, clk, arst_n, m_tvalid && res_s2.switched_to_pim, res_s2.in_pim_mode, "switch to PIM without PIM mode")
	`PMSP_ASSERT_IMP(a_phase_zero, clk, arst_n, m_tvalid && !res_s2.switched_to_mem && !res_s2.switched_to_pim, res_s2.phase_time == '0, "phase time without a switch")
	`PMSP_ASSERT_IMP(a_wasted_zero, clk, arst_n, m_tvalid && !res_s2.switched_to_pim, res_s2.wasted_cycles == '0, "wasted cycles without a switch to PIM")
	`PMSP_ASSERT_NXT(a_s1_kept, clk, arst_n, valid_s1 && !advance, valid_s1, "input stage item dropped while stalled")

endmodule

### rtl/pmsp_in_stage.sv
`timescale 1ns / 1ps

module pmsp_in_stage import pmsp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  logic  advance,
	input  item_t item_in,
	output item_t item_s1,
	output logic  valid_s1
);

	// valid flag of the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_in;
		end
	end

endmodule

### rtl/pmsp_core.sv
`timescale 1ns / 1ps

module pmsp_core import pmsp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item_s1,
	input  cfg_t    cfg,
	output result_t res
);

	// policy state
	logic               pim_mode_q;
	logic [COUNT_W-1:0] pim_count_q;
	logic [CYCLE_W-1:0] pim_start_q;
	logic [COUNT_W-1:0] batch_mark_q;
	logic [ROW_W-1:0]   last_row_q;
	logic [CYCLE_W-1:0] base_dur_q;
	logic [CYCLE_W-1:0] mem_start_q;
	logic [SBC_W-1:0]   sbc_q;

	logic               pim_mode_d;
	logic [COUNT_W-1:0] pim_count_d;
	logic [CYCLE_W-1:0] pim_start_d;
	logic [COUNT_W-1:0] batch_mark_d;
	logic [ROW_W-1:0]   last_row_d;
	logic [CYCLE_W-1:0] base_dur_d;
	logic [CYCLE_W-1:0] mem_start_d;
	logic [SBC_W-1:0]   sbc_d;

	logic [CYCLE_W-1:0] now;
	logic [CYCLE_W-1:0] pim_dur;
	logic [COUNT_W-1:0] batch;
	logic [COUNT_W:0]   batch_sum;
	logic               batch_end;
	logic               leave;
	logic [SBC_W-1:0]   now_x;
	logic [SBC_W-1:0]   wasted_x;

	assign now       = item_s1.cycle_now;
	assign now_x     = {{SLOW_W{1'b0}}, now};
	assign pim_dur   = now - pim_start_q;
	assign batch     = pim_count_q - batch_mark_q;
	assign batch_sum = {1'b0, pim_count_q} + {1'b0, batch};
	assign batch_end = (pim_start_q != '0)
		&& (!item_s1.pim_pending || item_s1.next_pim_row != last_row_q);
	assign leave     = (batch_end && batch_sum > {{(COUNT_W+1-CAP_W){1'b0}}, cfg.pim_cap})
		|| (pim_count_q > {{(COUNT_W-CAP_W){1'b0}}, cfg.pim_cap});
	assign wasted_x  = sbc_q - now_x;

	// mode decision, then this cycle's issue events
	always_comb begin
		pim_mode_d   = pim_mode_q;
		pim_count_d  = pim_count_q;
		pim_start_d  = pim_start_q;
		batch_mark_d = batch_mark_q;
		last_row_d   = last_row_q;
		base_dur_d   = base_dur_q;
		mem_start_d  = mem_start_q;
		sbc_d        = sbc_q;
		res          = '0;

		if (pim_mode_q) begin
			if (pim_count_q <= {{(COUNT_W-CAP_W){1'b0}}, cfg.pim_cap}) begin
				base_dur_d = pim_dur;
			end
			if (batch_end) begin
				batch_mark_d = pim_count_q;
			end
			if (leave && item_s1.mem_pending) begin
				res.phase_time      = pim_dur;
				res.switched_to_mem = 1'b1;
				sbc_d        = now_x + SBC_W'(cfg.slowdown_factor * base_dur_d);
				pim_count_d  = '0;
				pim_start_d  = '0;
				batch_mark_d = '0;
				last_row_d   = '0;
				pim_mode_d   = 1'b0;
			end
		end else begin
			if ((now_x > sbc_q || !item_s1.mem_pending) && item_s1.pim_pending) begin
				res.phase_time      = now - mem_start_q;
				res.switched_to_pim = 1'b1;
				if (now_x < sbc_q) begin
					// saturate at the field width
					if (wasted_x[SBC_W-1:CYCLE_W] != '0) begin
						res.wasted_cycles = '1;
					end else begin
						res.wasted_cycles = wasted_x[CYCLE_W-1:0];
					end
				end
				base_dur_d  = '0;
				mem_start_d = '0;
				sbc_d       = '0;
				pim_mode_d  = 1'b1;
			end
		end

		// issue bookkeeping, whatever the mode
		if (item_s1.mem_issued && mem_start_d == '0) begin
			mem_start_d = now;
		end
		if (item_s1.pim_issued) begin
			if (pim_start_d == '0) begin
				pim_start_d = now;
			end
			pim_count_d = pim_count_d + COUNT_W'(1);
			last_row_d  = item_s1.issued_pim_row;
		end

		res.in_pim_mode = pim_mode_d;
	end

	// state commits when the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pim_mode_q   <= 1'b0;
			pim_count_q  <= '0;
			pim_start_q  <= '0;
			batch_mark_q <= '0;
			last_row_q   <= '0;
			base_dur_q   <= '0;
			mem_start_q  <= '0;
			sbc_q        <= '0;
		end else if (advance) begin
			pim_mode_q   <= pim_mode_d;
			pim_count_q  <= pim_count_d;
			pim_start_q  <= pim_start_d;
			batch_mark_q <= batch_mark_d;
			last_row_q   <= last_row_d;
			base_dur_q   <= base_dur_d;
			mem_start_q  <= mem_start_d;
			sbc_q        <= sbc_d;
		end
	end

endmodule
